### sv/epwr_pkg.sv
// Package with the item types and constants of the echo pulse width ranger.
package epwr_pkg;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        overflow_flag;
    logic        capture_flag;
    logic [15:0] captured_count;
  } evt_item_t;

  typedef struct packed {
    logic        distance_valid;
    logic [19:0] distance;
    logic        counter_clear;
    logic        falling_edge_select;
  } res_item_t;

  localparam int unsigned OvfW     = 6;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DistW    = 20;

  localparam logic [OvfW-1:0]   OvfMax   = 6'h3F;
  localparam logic [CountW-1:0] SatCount = 16'hFFFF;

  // distance = (ovf*65536 + cnt)*17/100
  //          = ovf*11141 + (ovf*12 + cnt*17)/100   (65536*17 = 11141*100 + 12)
  localparam logic [DistW-1:0] OvfWhole = 20'd11141;
  localparam int unsigned      OvfFrac  = 12;
  localparam int unsigned      CntMul   = 17;
  localparam int unsigned      LowW     = 21;

  // divide a 19-bit value by 25: (y * ceil(2^24/25)) >> 24
  localparam int unsigned      RecipShift = 24;
  localparam logic [19:0]      Recip25    = 20'd671089;
  localparam int unsigned      QuotW      = 15;

endpackage

### sv/epwr_chan_if.sv
// Valid/ready channel interface carrying one item of a given type.
interface epwr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/echo_pulse_width_ranger.sv
// Top level of the echo pulse width ranger: pulse capture state and distance conversion.
//
//   channel  dir  item                   meaning
//   evt_i    in   epwr_pkg::evt_item_t   timer event or read request
//   res_o    out  epwr_pkg::res_item_t   one result for every accepted item
//
// One item per cycle sustained while res_o is ready.
// The item is held in an input register, where the state update and the conversion
// (one 19x20 reciprocal multiply) run, and the result lands in the output register.
// rst_ni clears the pulse state and both valid flags asynchronously.
// A stall on res_o holds the output register; the input register still drains into it
// once it frees, so evt_i keeps taking a new transfer whenever the pipeline advances.
module echo_pulse_width_ranger (
  input  logic clk_i,
  input  logic rst_ni,
  epwr_chan_if.sink   evt_i,
  epwr_chan_if.source res_o
);

  // Input register
  logic                s1_valid_q;
  epwr_pkg::evt_item_t s1_item_q;

  // Output register
  logic                res_valid_q;
  epwr_pkg::res_item_t res_item_q, res_item_d;

  // Pulse measurement state
  logic                           pulse_done_q, pulse_done_d;
  logic                           rising_seen_q, rising_seen_d;
  logic [epwr_pkg::OvfW-1:0]      overflow_count_q, overflow_count_d;
  logic [epwr_pkg::CountW-1:0]    end_count_q, end_count_d;
  logic                           edge_polarity_q, edge_polarity_d;

  logic advance;   // the output register can take the item in stage 1
  logic fire;      // the item in stage 1 moves to the output register

  assign advance     = !res_valid_q || res_o.ready;
  assign fire        = s1_valid_q && advance;
  assign evt_i.ready = !s1_valid_q || advance;

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_item_q;

  // ---------------------------------------------------------------------------
  // Distance conversion of the held pulse.
  // Split the tick count into the whole-wrap part and a small remainder part
  // so that only a narrow divide by 100 is left; do it as >>2 then *recip(25).
  // ---------------------------------------------------------------------------
  logic [epwr_pkg::LowW-1:0]  low_sum;
  logic [epwr_pkg::LowW-3:0]  low_quarter;
  logic [38:0]                recip_prod;
  logic [epwr_pkg::QuotW-1:0] low_quot;
  logic [epwr_pkg::DistW-1:0] dist_conv;

  assign low_sum = epwr_pkg::LowW'(end_count_q) * epwr_pkg::LowW'(epwr_pkg::CntMul)
                 + epwr_pkg::LowW'(overflow_count_q) * epwr_pkg::LowW'(epwr_pkg::OvfFrac);
  assign low_quarter = low_sum[epwr_pkg::LowW-1:2];
  assign recip_prod  = 39'(low_quarter) * 39'(epwr_pkg::Recip25);
  assign low_quot    = recip_prod[epwr_pkg::RecipShift +: epwr_pkg::QuotW];
  assign dist_conv   = epwr_pkg::DistW'(overflow_count_q) * epwr_pkg::OvfWhole
                     + epwr_pkg::DistW'(low_quot);

  // ---------------------------------------------------------------------------
  // Next state and result for the item in stage 1.
  // ---------------------------------------------------------------------------
  always_comb begin
    pulse_done_d     = pulse_done_q;
    rising_seen_d    = rising_seen_q;
    overflow_count_d = overflow_count_q;
    end_count_d      = end_count_q;
    edge_polarity_d  = edge_polarity_q;

    res_item_d                = '0;

    case (s1_item_q.op)
      epwr_pkg::OP_READ: begin
        // Convert a finished pulse and re-arm; otherwise report nothing.
        if (pulse_done_q) begin
          res_item_d.distance_valid = 1'b1;
          res_item_d.distance       = dist_conv;
          pulse_done_d              = 1'b0;
          rising_seen_d             = 1'b0;
          overflow_count_d          = '0;
        end
      end
      default: begin
        // Drop every event while a finished pulse waits to be read.
        if (!pulse_done_q) begin
          // Count wraps only inside a pulse; saturate at the top count.
          if (s1_item_q.overflow_flag && rising_seen_q) begin
            if (overflow_count_q == epwr_pkg::OvfMax) begin
              pulse_done_d = 1'b1;
              end_count_d  = epwr_pkg::SatCount;
            end else begin
              overflow_count_d = overflow_count_q + epwr_pkg::OvfW'(1);
            end
          end
          if (s1_item_q.capture_flag) begin
            if (rising_seen_q) begin
              // Falling edge: finish the pulse.
              pulse_done_d    = 1'b1;
              end_count_d     = s1_item_q.captured_count;
              edge_polarity_d = 1'b0;
            end else begin
              // Rising edge: start a measurement and clear the timer.
              pulse_done_d             = 1'b0;
              overflow_count_d         = '0;
              end_count_d              = '0;
              rising_seen_d            = 1'b1;
              edge_polarity_d          = 1'b1;
              res_item_d.counter_clear = 1'b1;
            end
          end
        end
      end
    endcase

    res_item_d.falling_edge_select = edge_polarity_d;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      res_valid_q      <= 1'b0;
      pulse_done_q     <= 1'b0;
      rising_seen_q    <= 1'b0;
      overflow_count_q <= '0;
      end_count_q      <= '0;
      edge_polarity_q  <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        s1_valid_q <= evt_i.valid;
      end
      if (advance) begin
        res_valid_q <= s1_valid_q;
      end
      if (fire) begin
        pulse_done_q     <= pulse_done_d;
        rising_seen_q    <= rising_seen_d;
        overflow_count_q <= overflow_count_d;
        end_count_q      <= end_count_d;
        edge_polarity_q  <= edge_polarity_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      s1_item_q <= evt_i.payload;
    end
    if (fire) begin
      res_item_q <= res_item_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_needs_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_done_q |-> rising_seen_q)
    else $error("pulse done without a rising edge");

  a_ovf_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rising_seen_q |-> (overflow_count_q == '0))
    else $error("overflow count nonzero outside a pulse");

  a_read_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_item_q.op == epwr_pkg::OP_READ && pulse_done_q)
      |=> !pulse_done_q && !rising_seen_q)
    else $error("read did not re-arm");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_item_q.distance_valid && res_item_q.counter_clear)
                    && (res_item_q.distance_valid || res_item_q.distance == '0))
    else $error("inconsistent result item");

endmodule

### test/epwr_pulse_checker.sv
// Checker for the echo pulse width ranger: predicts every result and compares it.
`timescale 1ns / 1ps
module epwr_pulse_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                evt_valid_i,
  input  logic                evt_ready_i,
  input  epwr_pkg::evt_item_t evt_item_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  epwr_pkg::res_item_t res_item_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned TicksPerWrap = 65536;
  localparam int unsigned DistMul      = 170;
  localparam int unsigned DistDiv      = 1000;
  localparam logic [5:0]  WrapLimit    = 6'h3F;
  localparam logic [15:0] FullCount    = 16'hFFFF;
  localparam int unsigned ReportLimit  = 10;

  // Predicted pulse state
  logic        done_q      = 1'b0;
  logic        armed_q     = 1'b0;
  logic [5:0]  wraps_q     = '0;
  logic [15:0] end_count_q = '0;
  logic        falling_q   = 1'b0;

  epwr_pkg::res_item_t expected_results[$];
  int unsigned         fails     = 0;
  int unsigned         pending_q = 0;

  // Apply one accepted item to the predicted state and return its result.
  function automatic epwr_pkg::res_item_t advance_pulse(epwr_pkg::evt_item_t it);
    epwr_pkg::res_item_t r;
    logic [31:0]         ticks;
    r = '0;
    if (it.op == epwr_pkg::OP_READ) begin
      if (done_q) begin
        ticks = 32'(wraps_q) * TicksPerWrap + 32'(end_count_q);
        r.distance_valid = 1'b1;
        r.distance       = 20'(ticks * DistMul / DistDiv);
        done_q  = 1'b0;
        armed_q = 1'b0;
        wraps_q = '0;
      end
    end else if (!done_q) begin
      if (it.overflow_flag && armed_q) begin
        if (wraps_q == WrapLimit) begin
          done_q      = 1'b1;
          end_count_q = FullCount;
        end else begin
          wraps_q = wraps_q + 6'd1;
        end
      end
      if (it.capture_flag) begin
        if (armed_q) begin
          done_q      = 1'b1;
          end_count_q = it.captured_count;
          falling_q   = 1'b0;
        end else begin
          wraps_q         = '0;
          end_count_q     = '0;
          armed_q         = 1'b1;
          falling_q       = 1'b1;
          r.counter_clear = 1'b1;
        end
      end
    end
    r.falling_edge_select = falling_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    epwr_pkg::res_item_t want;
    if (!rst_ni) begin
      done_q      = 1'b0;
      armed_q     = 1'b0;
      wraps_q     = '0;
      end_count_q = '0;
      falling_q   = 1'b0;
      expected_results.delete();
      pending_q   = 0;
    end else begin
      // Compare the output transfer first, then queue the prediction for the input one.
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          if (fails < ReportLimit)
            $display("%0t: result with nothing expected: valid=%0b dist=%0d clr=%0b fall=%0b",
                     $time, res_item_i.distance_valid, res_item_i.distance,
                     res_item_i.counter_clear, res_item_i.falling_edge_select);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (res_item_i.distance_valid !== want.distance_valid ||
              res_item_i.distance !== want.distance ||
              res_item_i.counter_clear !== want.counter_clear ||
              res_item_i.falling_edge_select !== want.falling_edge_select) begin
            if (fails < ReportLimit) begin
              $display("%0t: mismatch exp valid=%0b dist=%0d clr=%0b fall=%0b",
                       $time, want.distance_valid, want.distance, want.counter_clear,
                       want.falling_edge_select);
              $display("%0t: mismatch got valid=%0b dist=%0d clr=%0b fall=%0b",
                       $time, res_item_i.distance_valid, res_item_i.distance,
                       res_item_i.counter_clear, res_item_i.falling_edge_select);
            end
            fails++;
          end
        end
      end
      if (evt_valid_i && evt_ready_i)
        expected_results.push_back(advance_pulse(evt_item_i));
      pending_q = expected_results.size();
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = pending_q;

endmodule

### test/tb_echo_pulse_width_ranger.sv
// Testbench top for the echo pulse width ranger: stimulus, receiver pacing and verdict.
`timescale 1ns / 1ps
module tb_echo_pulse_width_ranger;

  // Cycle limit, far above the length of an honest run.
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned LongStall     = 80;
  localparam int unsigned ItemsPerPhase = 350;
  localparam int unsigned DrainCycles   = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          stall_armed;
  bit          stall_used;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_items  = 0;
  int unsigned fail_count;
  int unsigned pending;

  epwr_chan_if #(.T(epwr_pkg::evt_item_t)) evt_if ();
  epwr_chan_if #(.T(epwr_pkg::res_item_t)) res_if ();

  echo_pulse_width_ranger u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  epwr_pulse_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_valid_i  (evt_if.valid),
    .evt_ready_i  (evt_if.ready),
    .evt_item_i   (evt_if.payload),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_item_i   (res_if.payload),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL echo_pulse_width_ranger");
      $finish;
    end
  end

  // Result receiver. Hold ready low for one long stretch once armed, so the
  // pipeline fills and backs up into the event channel; otherwise drop ready
  // at the idle rate of the current phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_armed && !stall_used) begin
      res_if.ready <= 1'b0;
      stall_left   <= LongStall;
      stall_used   <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic epwr_pkg::evt_item_t make_item(epwr_pkg::op_e op, logic ovf,
                                                    logic cap, logic [15:0] cnt);
    epwr_pkg::evt_item_t it;
    it.op             = op;
    it.overflow_flag  = ovf;
    it.capture_flag   = cap;
    it.captured_count = cnt;
    return it;
  endfunction

  // Offer one item and hold it until the transfer. Insert random gaps before
  // it at the sender idle rate; valid stays high between back-to-back items.
  task automatic offer_item(epwr_pkg::evt_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid   <= 1'b1;
    evt_if.payload <= it;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic offer_noise();
    offer_item(make_item(epwr_pkg::op_e'($urandom_range(0, 1)), 1'($urandom), 1'($urandom),
                         16'($urandom)));
  endtask

  // Hand-picked corners: idle read, stray wraps, simultaneous wrap and
  // capture, events while a pulse is held, zero and full-scale counts.
  task automatic run_directed();
    offer_item(make_item(epwr_pkg::OP_READ,  1'b0, 1'b0, 16'h0000)); // read, nothing measured
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b1, 1'b0, 16'h0000)); // wrap before rising edge
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b0, 16'h1234)); // empty event
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b1, 1'b1, 16'hFFFF)); // wrap and rising capture
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b1, 1'b0, 16'h0000));
    offer_item(make_item(epwr_pkg::OP_READ,  1'b1, 1'b1, 16'hFFFF)); // read mid pulse
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b1, 1'b1, 16'hFFFF)); // wrap, falling capture
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b1, 16'h0005)); // capture while held
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b1, 1'b0, 16'h0000)); // wrap while held
    offer_item(make_item(epwr_pkg::OP_READ,  1'b0, 1'b0, 16'h0000)); // convert and re-arm
    offer_item(make_item(epwr_pkg::OP_READ,  1'b0, 1'b0, 16'h0000)); // second read is empty
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b1, 16'h1234));
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b1, 16'h0000)); // zero width pulse
    offer_item(make_item(epwr_pkg::OP_READ,  1'b1, 1'b0, 16'h5555));
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b1, 16'h0000));
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b1, 16'h8000));
    offer_item(make_item(epwr_pkg::OP_READ,  1'b0, 1'b1, 16'hAAAA));
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b1, 16'h7FFF));
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b1, 16'hFFFF)); // full count, no wraps
    offer_item(make_item(epwr_pkg::OP_READ,  1'b0, 1'b0, 16'h0000));
  endtask

  // One echo: rising capture, some wraps, falling capture, then usually a read.
  // A few echoes run long enough to saturate the wrap count.
  task automatic run_echo();
    int unsigned wraps;
    if ($urandom_range(0, 99) < 5) wraps = $urandom_range(62, 66);
    else wraps = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0)
      offer_item(make_item(epwr_pkg::OP_EVENT, 1'b1, 1'b0, 16'($urandom)));
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'($urandom), 1'b1, 16'($urandom)));
    for (int i = 0; i < wraps; i++) begin
      if ($urandom_range(0, 15) == 0)
        offer_item(make_item(epwr_pkg::OP_READ, 1'($urandom), 1'($urandom), 16'($urandom)));
      if ($urandom_range(0, 9) == 0)
        offer_item(make_item(epwr_pkg::OP_EVENT, 1'b0, 1'b0, 16'($urandom)));
      offer_item(make_item(epwr_pkg::OP_EVENT, 1'b1, 1'b0, 16'($urandom)));
    end
    offer_item(make_item(epwr_pkg::OP_EVENT, 1'($urandom), 1'b1, 16'($urandom)));
    if ($urandom_range(0, 4) == 0)
      offer_item(make_item(epwr_pkg::OP_EVENT, 1'($urandom), 1'($urandom), 16'($urandom)));
    if ($urandom_range(0, 9) != 0)
      offer_item(make_item(epwr_pkg::OP_READ, 1'($urandom), 1'($urandom), 16'($urandom)));
  endtask

  initial begin
    evt_if.valid   <= 1'b0;
    evt_if.payload <= '0;
    tx_idle_pct    <= 15;
    rx_idle_pct    <= 45;
    rst_ni         <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Three pacing phases: slow receiver, slow sender, then full rate with
    // one long receiver hold-off at its start.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct <= 15;
          rx_idle_pct <= 45;
        end
        1: begin
          tx_idle_pct <= 45;
          rx_idle_pct <= 15;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
          stall_armed <= 1'b1;
        end
      endcase
      sent_items = 0;
      while (sent_items < ItemsPerPhase) begin
        if ($urandom_range(0, 99) < 85) run_echo();
        else offer_noise();
      end
    end
    evt_if.valid <= 1'b0;

    // Wait for every predicted result, then watch a little longer for strays.
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS echo_pulse_width_ranger");
    end else begin
      $display("FAIL echo_pulse_width_ranger");
    end
    $finish;
  end

endmodule

### files.f
sv/epwr_pkg.sv
sv/epwr_chan_if.sv
sv/echo_pulse_width_ranger.sv
test/epwr_pulse_checker.sv
test/tb_echo_pulse_width_ranger.sv
